>>> hw/rtl/gn2_pkg.sv
package gn2_pkg;

  localparam int unsigned GridColsMaxDef = 64;
  localparam int unsigned GridRowsMaxDef = 64;
  localparam int unsigned AngleBitsDef   = 8;

  localparam logic CFG_GRID_COLS = 1'b0;
  localparam logic CFG_GRID_ROWS = 1'b1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  localparam logic [6:0] GridResetVal = 7'd64;

  localparam logic [14:0] QSIN [65] = '{
    15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,  15'd2801,
    15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,  15'd5520,  15'd5897,
    15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,  15'd8076,  15'd8423,  15'd8765,
    15'd9102,  15'd9434,  15'd9760,  15'd10080, 15'd10394, 15'd10702, 15'd11003, 15'd11297,
    15'd11585, 15'd11866, 15'd12140, 15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395,
    15'd13623, 15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978,
    15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
    15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379,
    15'd16384
  };

  typedef struct packed {
    logic signed [15:0] sin;
    logic signed [15:0] cos;
  } trig_t;

  function automatic logic signed [15:0] sine256(logic [7:0] k);
    logic [1:0]         q;
    logic [5:0]         r;
    logic signed [15:0] m;
    q = k[7:6];
    r = k[5:0];
    if (q[0]) begin
      m = $signed({1'b0, QSIN[7'd64 - {1'b0, r}]});
    end else begin
      m = $signed({1'b0, QSIN[{1'b0, r}]});
    end
    return q[1] ? -m : m;
  endfunction

endpackage

>>> hw/rtl/gn2_sincos.sv
module gn2_sincos #(
  parameter int unsigned ANGLE_BITS = 8
) (
  input  logic [ANGLE_BITS-1:0] angle_i,
  output gn2_pkg::trig_t        trig_o
);
  import gn2_pkg::*;

  localparam int unsigned Up   = (ANGLE_BITS < 8) ? 8 - ANGLE_BITS : 0;
  localparam int unsigned Dn   = (ANGLE_BITS > 8) ? ANGLE_BITS - 8 : 0;
  localparam int unsigned FrW  = (Dn > 0) ? Dn : 1;
  localparam int unsigned Half = (Dn > 0) ? (1 << (Dn - 1)) : 0;
  localparam int unsigned MW   = 17 + FrW + 1;

  function automatic logic signed [15:0] sine_of(logic [ANGLE_BITS-1:0] a);
    logic [7:0]            p;
    logic [FrW-1:0]        fr;
    logic signed [15:0]    s0;
    logic signed [15:0]    s1;
    logic signed [MW-1:0]  m;
    p  = 8'((32'(a) << Up) >> Dn);
    fr = FrW'(a) & FrW'((1 << Dn) - 1);
    s0 = sine256(p);
    s1 = sine256(p + 8'd1);
    m  = MW'(s1 - s0) * $signed({1'b0, fr});
    m  = (m + $signed(MW'(Half))) >>> Dn;
    return s0 + 16'(m);
  endfunction

  logic [ANGLE_BITS-1:0] cos_angle;

  assign cos_angle  = angle_i + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
  assign trig_o.sin = sine_of(angle_i);
  assign trig_o.cos = sine_of(cos_angle);

endmodule

>>> hw/rtl/gradient_noise_2d_unit.sv
// channel   direction  handshake                     payload
// item      in         start_i high, busy_o low      mode_i, point_x_i, point_y_i,
//                                                    entry_row_i, entry_col_i, entry_angle_i
// result    out        noise_valid_o for one cycle   noise_o
// config    in         cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// One item enters every cycle; busy_o stays low. A noise result is produced by the pipeline:
// an input register, four stages of modulo reduction, address, gradient memory read,
// sine/cosine, dot, two blend passes, and a final rounding and saturation stage.
// Write items update the gradient memory in the address stage and give no result.
// Reset clears valid bits and sets both grid sizes to 64; the memory is not cleared.
module gradient_noise_2d_unit #(
  parameter int unsigned GRID_COLS_MAX = gn2_pkg::GridColsMaxDef,
  parameter int unsigned GRID_ROWS_MAX = gn2_pkg::GridRowsMaxDef,
  parameter int unsigned ANGLE_BITS    = gn2_pkg::AngleBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               mode_i,
  input  logic [23:0]        point_x_i,
  input  logic [23:0]        point_y_i,
  input  logic [5:0]         entry_row_i,
  input  logic [5:0]         entry_col_i,
  input  logic [7:0]         entry_angle_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [6:0]         cfg_wdata_i,
  output logic               noise_valid_o,
  output logic signed [14:0] noise_o
);
  import gn2_pkg::*;

  localparam int unsigned XW    = $clog2(GRID_COLS_MAX);
  localparam int unsigned YW    = $clog2(GRID_ROWS_MAX);
  localparam int unsigned CW    = $clog2(GRID_COLS_MAX + 1);
  localparam int unsigned RW    = $clog2(GRID_ROWS_MAX + 1);
  localparam int unsigned Depth = GRID_COLS_MAX * GRID_ROWS_MAX;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned DW    = 26;
  localparam int unsigned PW    = 45;

  typedef struct packed {
    logic       mode;
    logic [7:0] xf;
    logic [7:0] yf;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] ang;
  } item_t;

  function automatic logic [XW-1:0] rem_x(logic [XW-1:0] r, logic [3:0] b, logic [CW-1:0] m);
    logic [XW:0] t;
    t = {1'b0, r};
    for (int i = 3; i >= 0; i--) begin
      t = {t[XW-1:0], b[i]};
      if (t >= (XW+1)'(m)) begin
        t = t - (XW+1)'(m);
      end
    end
    return t[XW-1:0];
  endfunction

  function automatic logic [YW-1:0] rem_y(logic [YW-1:0] r, logic [3:0] b, logic [RW-1:0] m);
    logic [YW:0] t;
    t = {1'b0, r};
    for (int i = 3; i >= 0; i--) begin
      t = {t[YW-1:0], b[i]};
      if (t >= (YW+1)'(m)) begin
        t = t - (YW+1)'(m);
      end
    end
    return t[YW-1:0];
  endfunction

  logic [6:0]    cols_q, rows_q;
  logic [CW-1:0] cols_use;
  logic [RW-1:0] rows_use;

  logic          vld_q [7];
  logic          evl_q [7:13];
  item_t         it_q  [8];
  logic [15:0]   xi_q  [4];
  logic [15:0]   yi_q  [4];
  logic [XW-1:0] rx_q  [1:4];
  logic [YW-1:0] ry_q  [1:4];

  logic [15:0]   fp_q [2];
  logic [21:0]   fq_q [2];
  logic [23:0]   ft_q [2];
  logic [45:0]   fn_q [2];
  logic [16:0]   wx_q [4:8];
  logic [16:0]   wy_q [4:10];

  logic                  we5_q;
  logic [AW-1:0]         wa5_q;
  logic [ANGLE_BITS-1:0] wd5_q;
  logic [AW-1:0]         ra5_q [4];

  logic [ANGLE_BITS-1:0] rd6_q  [4];

  trig_t                 trig   [4];
  trig_t                 trig7_q [4];
  logic signed [DW-1:0]  dot8_q [4];
  logic signed [PW-1:0]  px9_q  [2];
  logic signed [DW-1:0]  lo9_q  [2];
  logic signed [DW-1:0]  h10_q  [2];
  logic signed [PW-1:0]  py11_q;
  logic signed [DW-1:0]  lo11_q;
  logic signed [DW-1:0]  r12_q;
  logic signed [14:0]    noise_q;

  logic [XW-1:0] ix, ix1;
  logic [YW-1:0] iy, iy1;
  logic [CW:0]   nx;
  logic [RW:0]   ny;
  logic          wr_ok;

  assign busy_o        = 1'b0;
  assign noise_valid_o = evl_q[13];
  assign noise_o       = noise_q;

  always_comb begin
    if (cols_q == 7'd0) begin
      cols_use = CW'(1);
    end else if (32'(cols_q) > GRID_COLS_MAX) begin
      cols_use = CW'(GRID_COLS_MAX);
    end else begin
      cols_use = CW'(cols_q);
    end
    if (rows_q == 7'd0) begin
      rows_use = RW'(1);
    end else if (32'(rows_q) > GRID_ROWS_MAX) begin
      rows_use = RW'(GRID_ROWS_MAX);
    end else begin
      rows_use = RW'(rows_q);
    end
  end

  always_comb begin
    ix    = rx_q[4];
    iy    = ry_q[4];
    nx    = (CW+1)'(ix) + (CW+1)'(1);
    ny    = (RW+1)'(iy) + (RW+1)'(1);
    ix1   = (nx == (CW+1)'(cols_use)) ? '0 : XW'(nx);
    iy1   = (ny == (RW+1)'(rows_use)) ? '0 : YW'(ny);
    wr_ok = (it_q[3].mode == MODE_WRITE) && (32'(it_q[3].row) < GRID_ROWS_MAX) &&
            (32'(it_q[3].col) < GRID_COLS_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= GridResetVal;
      rows_q <= GridResetVal;
      for (int k = 0; k < 7; k++) vld_q[k] <= 1'b0;
      for (int k = 7; k <= 13; k++) evl_q[k] <= 1'b0;
      we5_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GRID_COLS: cols_q <= cfg_wdata_i;
          CFG_GRID_ROWS: rows_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      vld_q[0] <= start_i;
      for (int k = 1; k < 7; k++) vld_q[k] <= vld_q[k-1];
      evl_q[7] <= vld_q[6] && (it_q[6].mode == MODE_EVAL);
      for (int k = 8; k <= 13; k++) evl_q[k] <= evl_q[k-1];
      we5_q <= vld_q[3] && wr_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q[0] <= '{mode: mode_i, xf: point_x_i[7:0], yf: point_y_i[7:0],
                 row: entry_row_i, col: entry_col_i, ang: entry_angle_i};
    xi_q[0] <= point_x_i[23:8];
    yi_q[0] <= point_y_i[23:8];
    for (int k = 1; k < 8; k++) it_q[k] <= it_q[k-1];
    for (int k = 1; k < 4; k++) begin
      xi_q[k] <= xi_q[k-1];
      yi_q[k] <= yi_q[k-1];
    end

    rx_q[1] <= rem_x('0, xi_q[0][15:12], cols_use);
    ry_q[1] <= rem_y('0, yi_q[0][15:12], rows_use);
    for (int k = 2; k <= 4; k++) begin
      rx_q[k] <= rem_x(rx_q[k-1], xi_q[k-1][19-4*k -: 4], cols_use);
      ry_q[k] <= rem_y(ry_q[k-1], yi_q[k-1][19-4*k -: 4], rows_use);
    end

    fp_q[0] <= 16'(it_q[0].xf) * 16'(it_q[0].xf);
    fp_q[1] <= 16'(it_q[0].yf) * 16'(it_q[0].yf);
    fq_q[0] <= 22'(6 * fp_q[0]) + 22'd655360 - 22'(3840 * it_q[1].xf);
    fq_q[1] <= 22'(6 * fp_q[1]) + 22'd655360 - 22'(3840 * it_q[1].yf);
    ft_q[0] <= 24'(fp_q[0]) * 24'(it_q[1].xf);
    ft_q[1] <= 24'(fp_q[1]) * 24'(it_q[1].yf);
    for (int j = 0; j < 2; j++) fn_q[j] <= 46'(ft_q[j]) * 46'(fq_q[j]);
    wx_q[4] <= 17'((fn_q[0] + 46'd8388608) >> 24);
    wy_q[4] <= 17'((fn_q[1] + 46'd8388608) >> 24);
    for (int k = 5; k <= 8; k++) wx_q[k] <= wx_q[k-1];
    for (int k = 5; k <= 10; k++) wy_q[k] <= wy_q[k-1];

    wa5_q    <= AW'(it_q[3].row) * AW'(GRID_COLS_MAX) + AW'(it_q[3].col);
    wd5_q    <= ANGLE_BITS'(it_q[3].ang);
    ra5_q[0] <= AW'(iy)  * AW'(GRID_COLS_MAX) + AW'(ix);
    ra5_q[1] <= AW'(iy)  * AW'(GRID_COLS_MAX) + AW'(ix1);
    ra5_q[2] <= AW'(iy1) * AW'(GRID_COLS_MAX) + AW'(ix);
    ra5_q[3] <= AW'(iy1) * AW'(GRID_COLS_MAX) + AW'(ix1);
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [ANGLE_BITS-1:0] gtab_q [Depth];

    always_ff @(posedge clk_i) begin
      if (we5_q) begin
        gtab_q[wa5_q] <= wd5_q;
      end
      rd6_q[b] <= gtab_q[ra5_q[b]];
    end

    gn2_sincos #(
      .ANGLE_BITS(ANGLE_BITS)
    ) u_sincos (
      .angle_i(rd6_q[b]),
      .trig_o (trig[b])
    );
  end

  always_ff @(posedge clk_i) begin
    logic signed [8:0]    dx [4];
    logic signed [8:0]    dy [4];
    logic signed [DW-1:0] d0, d1, dh;
    logic signed [PW-1:0] pr;
    logic signed [17:0]   nr;
    logic signed [DW:0]   rr;

    dx[0] = $signed({1'b0, it_q[7].xf});
    dx[1] = $signed({1'b1, it_q[7].xf});
    dx[2] = dx[0];
    dx[3] = dx[1];
    dy[0] = $signed({1'b0, it_q[7].yf});
    dy[1] = dy[0];
    dy[2] = $signed({1'b1, it_q[7].yf});
    dy[3] = dy[2];

    for (int b = 0; b < 4; b++) begin
      trig7_q[b] <= trig[b];
      dot8_q[b]  <= DW'(dx[b]) * DW'(trig7_q[b].cos) + DW'(dy[b]) * DW'(trig7_q[b].sin);
    end

    d0 = dot8_q[1] - dot8_q[0];
    d1 = dot8_q[3] - dot8_q[2];
    px9_q[0] <= PW'($signed({1'b0, wx_q[8]})) * PW'(d0);
    px9_q[1] <= PW'($signed({1'b0, wx_q[8]})) * PW'(d1);
    lo9_q[0] <= dot8_q[0];
    lo9_q[1] <= dot8_q[2];

    for (int j = 0; j < 2; j++) begin
      pr = (px9_q[j] + PW'(32768)) >>> 16;
      h10_q[j] <= lo9_q[j] + DW'(pr);
    end

    dh = h10_q[1] - h10_q[0];
    py11_q <= PW'($signed({1'b0, wy_q[10]})) * PW'(dh);
    lo11_q <= h10_q[0];

    pr = (py11_q + PW'(32768)) >>> 16;
    r12_q <= lo11_q + DW'(pr);

    rr = ((DW+1)'(r12_q) + (DW+1)'(128)) >>> 8;
    nr = 18'(rr);
    if (nr > 18'sd16383) begin
      noise_q <= 15'sd16383;
    end else if (nr < -18'sd16384) begin
      noise_q <= -15'sd16384;
    end else begin
      noise_q <= 15'(nr);
    end
  end

endmodule
